/* rtl/wavhp_pkg.sv */
package wavhp_pkg;

  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [31:0] RATE_8K    = 32'd8000;
  localparam logic [31:0] RATE_16K   = 32'd16000;
  localparam logic [31:0] RATE_11K   = 32'd11025;
  localparam logic [31:0] RATE_22K   = 32'd22050;
  localparam logic [31:0] RATE_32K   = 32'd32000;
  localparam logic [31:0] RATE_44K   = 32'd44100;
  localparam logic [31:0] RATE_48K   = 32'd48000;

  localparam logic [15:0] BITS_8     = 16'd8;
  localparam logic [15:0] BITS_16    = 16'd16;
  localparam logic [31:0] FMT_BASE   = 32'd16;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_NO_FMT    = 4'd1,
    ST_NOT_PCM   = 4'd2,
    ST_CHANNELS  = 4'd3,
    ST_RATE      = 4'd4,
    ST_BITS      = 4'd5,
    ST_BYTE_RATE = 4'd6,
    ST_ALIGN     = 4'd7,
    ST_NO_DATA   = 4'd8
  } status_e;

  function automatic logic rate_ok(input logic [31:0] r);
    return r == RATE_8K  || r == RATE_16K || r == RATE_11K || r == RATE_22K ||
           r == RATE_32K || r == RATE_44K || r == RATE_48K;
  endfunction

endpackage

/* rtl/wavhp_fmt_chk.sv */
module wavhp_fmt_chk import wavhp_pkg::*; (
  input  logic [1:0]  channels_i,
  input  logic [31:0] rate_i,
  input  logic [31:0] byte_rate_i,
  input  logic [15:0] align_i,
  input  logic [15:0] bits_i,
  output status_e     status_o
);

  logic        bits_ok;
  logic [2:0]  frame_bytes;
  logic [33:0] exp_byte_rate;

  // channels already limited to 0..2 by the time bits arrive
  assign bits_ok       = (bits_i == BITS_8) || (bits_i == BITS_16);
  assign frame_bytes   = {1'b0, channels_i} << (bits_i == BITS_16);
  assign exp_byte_rate = {2'b00, rate_i} * 34'(frame_bytes);

  always_comb begin
    priority if (!bits_ok) begin
      status_o = ST_BITS;
    end else if ({2'b00, byte_rate_i} != exp_byte_rate) begin
      status_o = ST_BYTE_RATE;
    end else if (align_i != {13'd0, frame_bytes}) begin
      status_o = ST_ALIGN;
    end else begin
      status_o = ST_OK;
    end
  end

endmodule

/* rtl/wav_header_parser_unit.sv */
// A result is registered from the byte beat that completes it and appears the cycle after.
// Throughput: one byte beat per cycle; the output register lets a new byte
// enter while a result waits, as long as out_ready_i takes it that cycle.
// Reset (rst_ni low, async): parser waits for the first chunk id, all held
// fmt fields clear to zero, output register empties.
module wav_header_parser_unit import wavhp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        first_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] sample_rate_o,
  output logic [15:0] bits_per_sample_o,
  output logic [31:0] data_length_o
);

  typedef enum logic [3:0] {
    PH_ID1, PH_SIZE1, PH_SKIP1, PH_FMTSIZE, PH_TAG, PH_CH, PH_RATE, PH_BYTERATE,
    PH_ALIGN, PH_BITS, PH_EXT, PH_ID2, PH_SIZE2, PH_SKIP2, PH_DATASIZE, PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d, cur_phase;
  logic [1:0]  pos_q, pos_d, cur_pos;
  logic [31:0] shift_q, shift_d, cur_shift;
  logic [31:0] skip_q, skip_d, cur_skip;
  logic [15:0] chan_q, chan_d, cur_chan;
  logic [31:0] rate_q, rate_d, cur_rate;
  logic [31:0] brate_q, brate_d, cur_brate;
  logic [15:0] align_q, align_d, cur_align;
  logic [15:0] bits_q, bits_d, cur_bits;

  logic        in_fire;
  logic        emit;
  status_e     emit_status;
  logic [31:0] emit_len;
  logic [31:0] gv;
  logic        last2, last4;
  status_e     chk_status;

  logic        out_valid_q;
  logic [3:0]  status_q;
  logic [15:0] chan_out_q;
  logic [31:0] rate_out_q;
  logic [15:0] bits_out_q;
  logic [31:0] len_out_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // first byte of a new file restarts from the reset state
  assign cur_phase = first_byte_i ? PH_ID1 : phase_q;
  assign cur_pos   = first_byte_i ? 2'd0   : pos_q;
  assign cur_shift = first_byte_i ? '0     : shift_q;
  assign cur_skip  = first_byte_i ? '0     : skip_q;
  assign cur_chan  = first_byte_i ? '0     : chan_q;
  assign cur_rate  = first_byte_i ? '0     : rate_q;
  assign cur_brate = first_byte_i ? '0     : brate_q;
  assign cur_align = first_byte_i ? '0     : align_q;
  assign cur_bits  = first_byte_i ? '0     : bits_q;

  assign gv    = cur_shift | (32'(stream_byte_i) << {cur_pos, 3'b000});
  assign last2 = cur_pos == 2'd1;
  assign last4 = cur_pos == 2'd3;

  wavhp_fmt_chk u_fmt_chk (
    .channels_i  (cur_chan[1:0]),
    .rate_i      (cur_rate),
    .byte_rate_i (cur_brate),
    .align_i     (cur_align),
    .bits_i      (gv[15:0]),
    .status_o    (chk_status)
  );

  always_comb begin
    phase_d     = cur_phase;
    pos_d       = cur_pos + 2'd1;
    shift_d     = gv;
    skip_d      = cur_skip;
    chan_d      = cur_chan;
    rate_d      = cur_rate;
    brate_d     = cur_brate;
    align_d     = cur_align;
    bits_d      = cur_bits;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_len    = '0;

    unique case (cur_phase)
      PH_ID1, PH_ID2: begin
        if (last4) begin
          if (cur_phase == PH_ID1) begin
            phase_d = (gv == ID_FMT) ? PH_FMTSIZE : PH_SIZE1;
          end else begin
            phase_d = (gv == ID_DATA) ? PH_DATASIZE : PH_SIZE2;
          end
        end
      end
      PH_SIZE1, PH_SIZE2: begin
        if (last4) begin
          skip_d = gv;
          if (cur_phase == PH_SIZE1) begin
            phase_d = (gv != '0) ? PH_SKIP1 : PH_ID1;
          end else begin
            phase_d = (gv != '0) ? PH_SKIP2 : PH_ID2;
          end
        end
      end
      PH_SKIP1, PH_SKIP2, PH_EXT: begin
        pos_d   = cur_pos;
        shift_d = cur_shift;
        skip_d  = cur_skip - 32'd1;
        if (cur_skip == 32'd1) begin
          phase_d = (cur_phase == PH_SKIP1) ? PH_ID1 : PH_ID2;
        end
      end
      PH_FMTSIZE: begin
        if (last4) begin
          skip_d  = (gv[31] || gv < FMT_BASE) ? '0 : gv - FMT_BASE;
          phase_d = PH_TAG;
        end
      end
      PH_TAG: begin
        if (last2) begin
          if (gv[15:0] != 16'd1) begin
            emit        = 1'b1;
            emit_status = ST_NOT_PCM;
          end else begin
            phase_d = PH_CH;
          end
        end
      end
      PH_CH: begin
        if (last2) begin
          chan_d = gv[15:0];
          if (gv[15:0] > 16'd2) begin
            emit        = 1'b1;
            emit_status = ST_CHANNELS;
          end else begin
            phase_d = PH_RATE;
          end
        end
      end
      PH_RATE: begin
        if (last4) begin
          rate_d = gv;
          if (!rate_ok(gv)) begin
            emit        = 1'b1;
            emit_status = ST_RATE;
          end else begin
            phase_d = PH_BYTERATE;
          end
        end
      end
      PH_BYTERATE: begin
        if (last4) begin
          brate_d = gv;
          phase_d = PH_ALIGN;
        end
      end
      PH_ALIGN: begin
        if (last2) begin
          align_d = gv[15:0];
          phase_d = PH_BITS;
        end
      end
      PH_BITS: begin
        if (last2) begin
          bits_d = gv[15:0];
          if (chk_status != ST_OK) begin
            emit        = 1'b1;
            emit_status = chk_status;
          end else begin
            phase_d = (cur_skip != '0) ? PH_EXT : PH_ID2;
          end
        end
      end
      PH_DATASIZE: begin
        if (last4) begin
          emit        = 1'b1;
          emit_status = ST_OK;
          emit_len    = gv;
        end
      end
      PH_DONE: begin
        pos_d   = cur_pos;
        shift_d = cur_shift;
      end
    endcase

    // field complete: clear gather state
    if ((last2 && (cur_phase == PH_TAG || cur_phase == PH_CH ||
                   cur_phase == PH_ALIGN || cur_phase == PH_BITS)) ||
        (last4 && (cur_phase == PH_ID1 || cur_phase == PH_ID2 ||
                   cur_phase == PH_SIZE1 || cur_phase == PH_SIZE2 ||
                   cur_phase == PH_FMTSIZE || cur_phase == PH_RATE ||
                   cur_phase == PH_BYTERATE || cur_phase == PH_DATASIZE))) begin
      pos_d   = 2'd0;
      shift_d = '0;
    end

    if (!emit && end_of_file_i && cur_phase != PH_DONE && phase_d != PH_DONE) begin
      emit        = 1'b1;
      emit_status = (phase_d <= PH_EXT) ? ST_NO_FMT : ST_NO_DATA;
    end

    if (emit) begin
      phase_d = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID1;
      pos_q   <= '0;
      shift_q <= '0;
      skip_q  <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      brate_q <= '0;
      align_q <= '0;
      bits_q  <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      skip_q  <= skip_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      brate_q <= brate_d;
      align_q <= align_d;
      bits_q  <= bits_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      status_q   <= emit_status;
      chan_out_q <= chan_d;
      rate_out_q <= rate_d;
      bits_out_q <= bits_d;
      len_out_q  <= emit_len;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign channel_count_o   = chan_out_q;
  assign sample_rate_o     = rate_out_q;
  assign bits_per_sample_o = bits_out_q;
  assign data_length_o     = len_out_q;

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !first_byte_i && phase_q == PH_DONE |-> !emit && phase_d == PH_DONE)
    else $error("parse done but beat produced a result");

  a_emit_ends_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && emit |=> out_valid_q && phase_q == PH_DONE)
    else $error("result not registered or parse not closed");

  a_skip_no_gather: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP1 || phase_q == PH_SKIP2 || phase_q == PH_EXT)
      |-> pos_q == 2'd0 && skip_q != '0)
    else $error("skip phase with pending field bytes or zero count");

  a_ok_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && emit && emit_status == ST_OK |-> cur_phase == PH_DATASIZE)
    else $error("ok result outside data size field");

endmodule
